### hw/rtl/dcr_pkg.sv
// Shared types for the block DC removal design.
// Holds the controller states and the command and status bundles.
// No dependencies.
package dcr_pkg;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DIVIDE = 2'd1,
      ST_READ   = 2'd2
   } dcr_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic take;       // request accepted this cycle
      logic div_step;   // advance the mean divider one bit
      logic emit_read;  // build the drain response from the read sample
   } dcr_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic load_last;  // pending request is a load that closes the block
      logic drain_ok;   // pending request is a drain with a sample to give
      logic rsp_free;   // output register is empty or empties this cycle
      logic div_done;   // divider is on its last step
   } dcr_status_type;

endpackage

### hw/rtl/dcr_ctrl.sv
// Controller state machine for the block DC removal design.
// Sequences accept, mean division and drain read. Depends on dcr_pkg.
module dcr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  dcr_pkg::dcr_status_type st,
   output logic                    req_stall,
   output dcr_pkg::dcr_cmd_type    cmd
);
   import dcr_pkg::*;

   dcr_state_type state_ff;
   dcr_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !st.rsp_free;
            cmd.take  = req_valid && st.rsp_free;
            if (cmd.take) begin
               if (st.load_last) begin
                  state_in = ST_DIVIDE;
               end else if (st.drain_ok) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (st.div_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.emit_read = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/dcr_datapath.sv
// Datapath for the block DC removal design: sample store, running sum,
// restoring mean divider and response register. Depends on dcr_pkg.
module dcr_datapath #(
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dcr_pkg::dcr_cmd_type          cmd,
   output dcr_pkg::dcr_status_type       st,
   input  logic                          req_operation,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_block_end,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic signed [SAMPLE_BITS:0]   rsp_corrected,
   output logic                          rsp_final_out,
   output logic                          rsp_error_flag
);
   import dcr_pkg::*;

   localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_SAMPLES);
   localparam int STEP_W = $clog2(SUM_W);
   localparam int CORR_W = SAMPLE_BITS + 1;

   // Sample store
   logic [SAMPLE_BITS-1:0] store [MAX_SAMPLES];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic                   mem_we;
   logic [ADDR_W-1:0]      wr_addr;

   // Block state
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       ridx_ff, ridx_in;
   logic                   closed_ff, closed_in;
   logic                   ovf_ff, ovf_in;

   // Divider
   logic [SUM_W-1:0]       dq_ff, dq_in;
   logic [CNT_W-1:0]       rem_ff, rem_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   neg_ff, neg_in;
   logic [SAMPLE_BITS-1:0] mean_ff, mean_in;

   // Response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CORR_W-1:0]      corr_ff, corr_in;
   logic                   final_ff, final_in;
   logic                   err_ff, err_in;

   // Helpers
   logic [SUM_W-1:0]       sample_ext;
   logic [SUM_W-1:0]       sum_base, sum_add, sum_next;
   logic [CNT_W-1:0]       count_base;
   logic                   room;
   logic [CNT_W:0]         rem_sh;
   logic                   q_bit;
   logic [SUM_W-1:0]       q_fin;
   logic [CNT_W-1:0]       ridx_inc;

   // Status toward the controller
   always_comb begin
      st.load_last = !req_operation && req_block_end;
      st.drain_ok  = req_operation && closed_ff && (count_ff != '0) && (ridx_ff < count_ff);
      st.rsp_free  = !rsp_valid_ff || !rsp_stall;
      st.div_done  = (step_ff == STEP_W'(SUM_W - 1));
   end

   // Load arithmetic: a load after a closed block starts from an empty block
   always_comb begin
      sample_ext = {{(SUM_W - SAMPLE_BITS){req_sample[SAMPLE_BITS-1]}}, req_sample};
      sum_base   = closed_ff ? '0 : sum_ff;
      count_base = closed_ff ? '0 : count_ff;
      room       = (count_base < CNT_W'(MAX_SAMPLES));
      sum_add    = sum_base + sample_ext;
      sum_next   = room ? sum_add : sum_base;
      wr_addr    = count_base[ADDR_W-1:0];
      ridx_inc   = ridx_ff + 1'b1;
   end

   // Divider step: shift in one dividend bit, subtract the count if it fits
   always_comb begin
      rem_sh = {rem_ff, dq_ff[SUM_W-1]};
      q_bit  = (rem_sh >= {1'b0, count_ff});
      q_fin  = {dq_ff[SUM_W-2:0], q_bit};
   end

   // Next state of block, divider and response
   always_comb begin
      sum_in       = sum_ff;
      count_in     = count_ff;
      ridx_in      = ridx_ff;
      closed_in    = closed_ff;
      ovf_in       = ovf_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      mean_in      = mean_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      corr_in      = corr_ff;
      final_in     = final_ff;
      err_in       = err_ff;
      mem_we       = 1'b0;

      if (cmd.take) begin
         if (!req_operation) begin
            if (closed_ff) begin
               closed_in = 1'b0;
               ovf_in    = 1'b0;
               ridx_in   = '0;
            end
            sum_in = sum_next;
            if (room) begin
               mem_we   = 1'b1;
               count_in = count_base + 1'b1;
            end else begin
               count_in     = count_base;
               ovf_in       = 1'b1;
               rsp_valid_in = 1'b1;
               corr_in      = '0;
               final_in     = 1'b0;
               err_in       = 1'b1;
            end
            // Close the block and launch the mean division
            if (req_block_end) begin
               closed_in = 1'b1;
               ridx_in   = '0;
               neg_in    = sum_next[SUM_W-1];
               dq_in     = sum_next[SUM_W-1] ? (~sum_next + 1'b1) : sum_next;
               rem_in    = '0;
               step_in   = '0;
            end
         end else if (!st.drain_ok) begin
            rsp_valid_in = 1'b1;
            corr_in      = '0;
            final_in     = 1'b0;
            err_in       = 1'b1;
         end
      end

      if (cmd.div_step) begin
         rem_in  = q_bit ? CNT_W'(rem_sh - {1'b0, count_ff}) : rem_sh[CNT_W-1:0];
         dq_in   = q_fin;
         step_in = step_ff + 1'b1;
         if (st.div_done) begin
            mean_in = neg_ff ? (~q_fin[SAMPLE_BITS-1:0] + 1'b1) : q_fin[SAMPLE_BITS-1:0];
         end
      end

      // Drain response from the registered store read
      if (cmd.emit_read) begin
         rsp_valid_in = 1'b1;
         corr_in      = {rd_data_ff[SAMPLE_BITS-1], rd_data_ff}
                        - {mean_ff[SAMPLE_BITS-1], mean_ff};
         final_in     = (ridx_inc == count_ff);
         err_in       = ovf_ff;
         ridx_in      = ridx_inc;
      end
   end

   // Store write and registered read at the drain pointer
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[wr_addr] <= req_sample;
      end
      rd_data_ff <= store[ridx_ff[ADDR_W-1:0]];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         ridx_ff      <= '0;
         closed_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ridx_ff      <= ridx_in;
         closed_ff    <= closed_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      neg_ff   <= neg_in;
      mean_ff  <= mean_in;
      corr_ff  <= corr_in;
      final_ff <= final_in;
      err_ff   <= err_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_corrected  = corr_ff;
   assign rsp_final_out  = final_ff;
   assign rsp_error_flag = err_ff;

   // Fill count never passes the store depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count beyond store depth");

   // Drain pointer stays within the filled part
   a_ridx_in_block: assert property (@(posedge clock) disable iff (reset)
      ridx_ff <= count_ff)
      else $error("drain pointer beyond sample count");

   // A drain response only lands in an empty output register
   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_read |-> !rsp_valid_ff)
      else $error("drain response overwrites pending response");

   // Division never runs against an empty block
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (count_ff != '0) && closed_ff)
      else $error("mean division with empty or open block");

   // A load without the end flag leaves the block open
   a_load_opens: assert property (@(posedge clock) disable iff (reset)
      (cmd.take && !req_operation && !req_block_end) |=> !closed_ff)
      else $error("block closed by a non-final load");

endmodule

### hw/rtl/block_dc_removal.sv
// Top level of the block DC removal design: controller and datapath.
// Depends on dcr_pkg, dcr_ctrl and dcr_datapath.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  req_operation, req_sample, req_block_end
//   rsp       out         rsp_valid / rsp_stall  rsp_corrected, rsp_final_out, rsp_error_flag
//
// A load with block_end set also runs the mean division, one quotient bit
// a cycle, over all SAMPLE_BITS + clog2(MAX_SAMPLES) bits of the sum. A
// drain passes through the read state, as its response is built from the
// registered read of the sample store. Synchronous reset empties the block;
// the store needs no clearing. req_stall is high while a division or read is
// under way, and while a response is held in the output register by rsp_stall.
module block_dc_removal #(
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_block_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS:0]   rsp_corrected,
   output logic                          rsp_final_out,
   output logic                          rsp_error_flag
);
   import dcr_pkg::*;

   dcr_cmd_type    cmd;
   dcr_status_type st;

   // Sequencer
   dcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .st        (st),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   // Store, sum, divider and response register
   dcr_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .req_operation  (req_operation),
      .req_sample     (req_sample),
      .req_block_end  (req_block_end),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_corrected  (rsp_corrected),
      .rsp_final_out  (rsp_final_out),
      .rsp_error_flag (rsp_error_flag)
   );

endmodule

### sim/tb_block_dc_removal.sv
// Testbench for block_dc_removal: loads and drains sample blocks through the
// request channel and checks each response against a built-in predictor.
// Depends only on the block_dc_removal RTL and its package.
`timescale 1ns / 100ps

module tb_block_dc_removal;

   localparam int SW             = 24;
   localparam int DEPTH          = 4096;
   localparam int S_MAX          = 8388607;
   localparam int S_MIN          = -8388608;
   localparam int RAND_ITEMS     = 1830;
   localparam int HOLD_CYCLES    = 300;
   localparam int TAIL_CYCLES    = 60;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct {
      logic signed [SW:0] corrected;
      logic               final_out;
      logic               error_flag;
   } rsp_item_type;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic                 req_operation  = OP_LOAD;
   logic signed [SW-1:0] req_sample     = '0;
   logic                 req_block_end  = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic signed [SW:0]   rsp_corrected;
   logic                 rsp_final_out;
   logic                 rsp_error_flag;

   // Predictor state: shadow of the sample buffer and block bookkeeping
   logic signed [SW-1:0] shadow_store [DEPTH];
   longint               blk_sum      = 0;
   longint               blk_mean     = 0;
   int                   blk_count    = 0;
   int                   rd_index     = 0;
   bit                   blk_closed   = 1'b0;
   bit                   blk_overflow = 1'b0;

   rsp_item_type         expected_rsp [$];
   rsp_item_type         head_rsp;

   bit                   idle_on         = 1'b1;
   int                   hold_rsp_cycles = 0;
   int                   quiet_cycles    = 0;
   int                   fails           = 0;
   int                   n_loads         = 0;
   int                   n_drains        = 0;
   int                   n_rsp           = 0;

   block_dc_removal #(
      .MAX_SAMPLES(DEPTH),
      .SAMPLE_BITS(SW)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_sample    (req_sample),
      .req_block_end (req_block_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_corrected (rsp_corrected),
      .rsp_final_out (rsp_final_out),
      .rsp_error_flag(rsp_error_flag)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predict the response, if any, of one accepted request
   task automatic dc_predict(input logic op, input logic signed [SW-1:0] smp,
                             input logic last);
      rsp_item_type item;
      longint       diff;
      item = '{corrected: '0, final_out: 1'b0, error_flag: 1'b1};
      if (op == OP_LOAD) begin
         // a load after a closed block starts a fresh one
         if (blk_closed) begin
            blk_sum      = 0;
            blk_mean     = 0;
            blk_count    = 0;
            rd_index     = 0;
            blk_closed   = 1'b0;
            blk_overflow = 1'b0;
         end
         if (blk_count < DEPTH) begin
            shadow_store[blk_count] = smp;
            blk_sum   += longint'(smp);
            blk_count++;
         end else begin
            blk_overflow = 1'b1;
            expected_rsp.push_back(item);
         end
         // close the block and form the mean, truncated toward zero
         if (last) begin
            blk_closed = 1'b1;
            rd_index   = 0;
            blk_mean   = (blk_count != 0) ? blk_sum / longint'(blk_count) : 0;
         end
      end else if (!blk_closed || blk_count == 0 || rd_index >= blk_count) begin
         expected_rsp.push_back(item);
      end else begin
         diff            = longint'(shadow_store[rd_index]) - blk_mean;
         item.corrected  = diff[SW:0];
         item.final_out  = (rd_index + 1 == blk_count);
         item.error_flag = blk_overflow;
         rd_index++;
         expected_rsp.push_back(item);
      end
   endtask

   // Offer one request, hold it until accepted, then predict it
   task automatic send_req(input logic op, input logic signed [SW-1:0] smp,
                           input logic last);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_sample    <= smp;
      req_block_end <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      dc_predict(op, smp, last);
      if (op == OP_LOAD) n_loads++;
      else n_drains++;
   endtask

   // Stop offering requests until every expected response has come back
   task automatic wait_all_done();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp.size() != 0);
   endtask

   function automatic logic signed [SW-1:0] pick_sample(input int dc);
      int v;
      case ($urandom_range(0, 9))
         0:       pick_sample = SW'(S_MAX);
         1:       pick_sample = SW'(S_MIN);
         2, 3:    pick_sample = SW'($urandom);
         4:       pick_sample = SW'(int'($urandom_range(0, 32)) - 16);
         default: begin
            // DC level plus noise, clamped to the sample range
            v = dc + int'($urandom_range(0, 4096)) - 2048;
            if (v > S_MAX) v = S_MAX;
            else if (v < S_MIN) v = S_MIN;
            pick_sample = SW'(v);
         end
      endcase
   endfunction

   // Short blocks covering empty drains, open blocks, truncation and discard
   task automatic test_directed();
      send_req(OP_DRAIN, '0, 1'b0);
      send_req(OP_LOAD, SW'(-1), 1'b0);
      send_req(OP_DRAIN, '0, 1'b0);
      // sum -3 over 2 gives a mean of -1, not -2
      send_req(OP_LOAD, SW'(-2), 1'b1);
      repeat (3) send_req(OP_DRAIN, '1, 1'b1);
      send_req(OP_LOAD, SW'(S_MAX), 1'b0);
      send_req(OP_LOAD, SW'(S_MIN), 1'b0);
      send_req(OP_LOAD, '0, 1'b0);
      send_req(OP_LOAD, SW'(1), 1'b1);
      repeat (2) send_req(OP_DRAIN, '0, 1'b0);
      // new block drops the two samples never drained
      send_req(OP_LOAD, SW'(5), 1'b0);
      send_req(OP_LOAD, SW'(2), 1'b1);
      send_req(OP_LOAD, SW'(7), 1'b1);
      send_req(OP_DRAIN, '0, 1'b0);
      send_req(OP_LOAD, 24'h555555, 1'b0);
      send_req(OP_LOAD, 24'hAAAAAA, 1'b1);
      repeat (2) send_req(OP_DRAIN, 24'hAAAAAA, 1'b0);
      wait_all_done();
   endtask

   // Hold the response side for a long stretch while drains keep coming
   task automatic test_output_hold();
      int k;
      int dc;
      idle_on = 1'b0;
      dc      = int'($urandom_range(0, 16000000)) - 8000000;
      for (k = 0; k < 48; k++) send_req(OP_LOAD, pick_sample(dc), k == 47);
      hold_rsp_cycles = HOLD_CYCLES;
      repeat (50) send_req(OP_DRAIN, SW'($urandom), 1'b0);
      wait_all_done();
      idle_on = 1'b1;
   endtask

   // Random blocks with random content, plus noise and broken sequences
   task automatic test_random_blocks();
      int start;
      int sent;
      int blk_len;
      int n_drain;
      int dc;
      int k;
      start = n_loads + n_drains;
      sent  = 0;
      while (sent < RAND_ITEMS) begin
         idle_on = (sent < RAND_ITEMS * 85 / 100) && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 10))
               send_req(1'($urandom_range(0, 1)), SW'($urandom),
                        1'($urandom_range(0, 1)));
         end else begin
            blk_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 32);
            dc      = int'($urandom_range(0, 16000000)) - 8000000;
            for (k = 0; k < blk_len; k++) begin
               // drain into the open block now and then
               if (k > 0 && $urandom_range(0, 29) == 0)
                  send_req(OP_DRAIN, SW'($urandom), 1'($urandom_range(0, 1)));
               send_req(OP_LOAD, pick_sample(dc), k == blk_len - 1);
            end
            case ($urandom_range(0, 5))
               0:       n_drain = $urandom_range(0, blk_len - 1);
               1:       n_drain = blk_len + $urandom_range(1, 3);
               default: n_drain = blk_len;
            endcase
            repeat (n_drain) send_req(OP_DRAIN, SW'($urandom), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 7) == 0) wait_all_done();
         end
         sent = n_loads + n_drains - start;
      end
      idle_on = 1'b0;
      wait_all_done();
   endtask

   // Response side idling: random bursts and the long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_rsp_cycles) @(posedge clock);
            hold_rsp_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         n_rsp++;
         if (expected_rsp.size() == 0) begin
            $display("%0t: response with none expected: corrected %0d final %b error %b",
                     $time, rsp_corrected, rsp_final_out, rsp_error_flag);
            fails++;
         end else begin
            head_rsp = expected_rsp.pop_front();
            if (rsp_corrected !== head_rsp.corrected) begin
               $display("%0t: corrected expected %0d actual %0d",
                        $time, head_rsp.corrected, rsp_corrected);
               fails++;
            end
            if (rsp_final_out !== head_rsp.final_out) begin
               $display("%0t: final_out expected %b actual %b",
                        $time, head_rsp.final_out, rsp_final_out);
               fails++;
            end
            if (rsp_error_flag !== head_rsp.error_flag) begin
               $display("%0t: error_flag expected %b actual %b",
                        $time, head_rsp.error_flag, rsp_error_flag);
               fails++;
            end
         end
      end
   end

   // Count cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   // End the run if traffic stops for too long
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_output_hold();
      test_random_blocks();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, expected_rsp.size());
         fails++;
      end
      $display("Run: %0d loads, %0d drains, %0d responses checked, %0d mismatches",
               n_loads, n_drains, n_rsp, fails);
      $display("Run: empty and open-block drains, negative-mean truncation, %s",
               "long output hold, random blocks");
      if (fails == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/dcr_pkg.sv
hw/rtl/dcr_ctrl.sv
hw/rtl/dcr_datapath.sv
hw/rtl/block_dc_removal.sv
sim/tb_block_dc_removal.sv
